// ===== hw/rtl/snfcs_pkg.sv =====
// shared types and constants for the spi nor flash command sequencer
`default_nettype none

package snfcs_pkg;

  // request codes carried on in_tuser
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_READ   = 3'd1,
    OP_PROG   = 3'd2,
    OP_BYTE   = 3'd3,
    OP_SECT   = 3'd4,
    OP_BULK   = 3'd5,
    OP_STAT   = 3'd6,
    OP_UNUSED = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_SHIFT = 3'd2,
    PH_STOP  = 3'd3,
    PH_WAIT  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FR_WREN = 2'd0,
    FR_MAIN = 2'd1,
    FR_POLL = 2'd2,
    FR_WRDI = 2'd3
  } frame_t;

  typedef enum logic [1:0] {
    FIN_NONE    = 2'd0,
    FIN_OK      = 2'd1,
    FIN_TIMEOUT = 2'd2,
    FIN_RSVD    = 2'd3
  } fin_t;

  typedef enum logic [2:0] {
    CFG_BUSY_MASK = 3'd0,
    CFG_POLL_IVL  = 3'd1,
    CFG_TO_PROG   = 3'd2,
    CFG_TO_SECT   = 3'd3,
    CFG_TO_BULK   = 3'd4
  } cfg_idx_t;

  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_SE   = 8'hD8;
  localparam logic [7:0] CMD_BE   = 8'hC7;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_WRDI = 8'h04;

  localparam logic [7:0]  RST_BUSY_MASK = 8'd1;
  localparam logic [15:0] RST_POLL_IVL  = 16'd1000;
  localparam logic [31:0] RST_TO_PROG   = 32'd100000;
  localparam logic [31:0] RST_TO_SECT   = 32'd10000000;
  localparam logic [31:0] RST_TO_BULK   = 32'd200000000;

endpackage

`default_nettype wire

// ===== hw/rtl/spi_nor_flash_command_sequencer.sv =====
// spi mode-0 command sequencer for serial nor flash, one half sck per word
`default_nettype none

// Each input word is one half period of SCK (or, while idle, a request that only
// latches) and produces exactly one output word with the pin levels after that
// step. A word enters an input register, the sequencer state advances in one
// pass of logic and the result lands in an output register, so the block takes
// one word per clock cycle whenever the output side is not stalled. The state
// update of the frame/bit/poll sequencer, done in one pass of logic, sets this
// rate. Program data is offered with a program-byte word whenever want_byte is
// high; SCK holds low until it arrives.
module spi_nor_flash_command_sequencer
  import snfcs_pkg::*;
#(
  parameter int ADDR_BYTES = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // operation[2:0]
  input  wire logic [2:0]  in_tuser,
  // address[23:0], length[48:24], write_byte[56:49], miso[57], zero fill
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cs_n[0], sclk[1], mosi[2], read_byte[10:3], read_valid[11], want_byte[12],
  // busy_res[13], finish[15:14]
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int POS_W = $clog2(ADDR_BYTES + 2);

  // configuration
  logic [7:0]  busy_mask_r;
  logic [15:0] poll_ivl_r;
  logic [31:0] to_prog_r, to_sect_r, to_bulk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_mask_r <= RST_BUSY_MASK;
      poll_ivl_r  <= RST_POLL_IVL;
      to_prog_r   <= RST_TO_PROG;
      to_sect_r   <= RST_TO_SECT;
      to_bulk_r   <= RST_TO_BULK;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BUSY_MASK: busy_mask_r <= cfg_wdata[7:0];
        CFG_POLL_IVL:  poll_ivl_r  <= cfg_wdata[15:0];
        CFG_TO_PROG:   to_prog_r   <= cfg_wdata;
        CFG_TO_SECT:   to_sect_r   <= cfg_wdata;
        CFG_TO_BULK:   to_bulk_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic        in_v_r;
  op_t         in_op_r;
  logic [23:0] in_addr_r;
  logic [24:0] in_len_r;
  logic [7:0]  in_wbyte_r;
  logic        in_miso_r;
  logic        out_v_r;
  logic [15:0] out_data_r;
  logic        out_last_r;
  logic        adv;
  logic        in_acc;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r    <= op_t'(in_tuser);
      in_addr_r  <= in_tdata[23:0];
      in_len_r   <= in_tdata[48:24];
      in_wbyte_r <= in_tdata[56:49];
      in_miso_r  <= in_tdata[57];
    end
  end

  // sequencer state
  phase_t             phase_r, phase_nxt;
  frame_t             frame_r, frame_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic               half_r, half_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [24:0]        left_r, left_nxt;
  logic [23:0]        addr_r, addr_nxt;
  op_t                kind_r, kind_nxt;
  logic [31:0]        budget_r, budget_nxt;
  logic [15:0]        pcnt_r, pcnt_nxt;
  logic               cs_r, cs_nxt;
  logic               sck_r, sck_nxt;
  logic               mosi_r, mosi_nxt;
  logic [7:0]         bbyte_r, bbyte_nxt;
  logic               bvalid_r, bvalid_nxt;
  logic               cdata_r, cdata_nxt;
  logic               ready_r, ready_nxt;
  logic               tmo_r, tmo_nxt;
  logic               buf_stall;

  // frame shape from current state
  logic               addr_kind;
  logic [POS_W-1:0]   hlen;
  logic               has_data;
  logic [POS_W-1:0]   hb_i;
  logic [1:0]         hb_sel;
  logic [31:0]        addr_ext;
  logic [7:0]         hdr_byte;
  logic [15:0]        ivl;
  logic [31:0]        wait_w;
  logic [7:0]         shifted;

  assign addr_kind = (kind_r == OP_READ) || (kind_r == OP_PROG) || (kind_r == OP_SECT);
  assign hlen      = (frame_r == FR_MAIN && addr_kind) ? POS_W'(ADDR_BYTES + 1) : POS_W'(1);
  assign has_data  = (frame_r == FR_POLL) ||
                     (frame_r == FR_MAIN &&
                      (kind_r == OP_READ || kind_r == OP_PROG || kind_r == OP_STAT));
  assign hb_i      = pos_r - POS_W'(1);
  assign hb_sel    = 2'(POS_W'(ADDR_BYTES - 1) - hb_i);
  // leading byte of a four-byte address is zero
  assign addr_ext  = {8'h00, addr_r};
  assign shifted   = {shift_r[6:0], in_miso_r};

  always_comb begin
    if (pos_r == '0) begin
      case (frame_r)
        FR_WREN: hdr_byte = CMD_WREN;
        FR_WRDI: hdr_byte = CMD_WRDI;
        FR_POLL: hdr_byte = CMD_RDSR;
        default: begin
          case (kind_r)
            OP_READ: hdr_byte = CMD_READ;
            OP_PROG: hdr_byte = CMD_PP;
            OP_SECT: hdr_byte = CMD_SE;
            OP_BULK: hdr_byte = CMD_BE;
            default: hdr_byte = CMD_RDSR;
          endcase
        end
      endcase
    end else if (hb_i < POS_W'(ADDR_BYTES)) begin
      hdr_byte = addr_ext[hb_sel*8 +: 8];
    end else begin
      hdr_byte = 8'h00;
    end
  end

  assign ivl    = (poll_ivl_r == 16'd0) ? 16'd1 : poll_ivl_r;
  assign wait_w = (budget_r < {16'd0, ivl}) ? budget_r : {16'd0, ivl};

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    frame_nxt  = frame_r;
    pos_nxt    = pos_r;
    bit_nxt    = bit_r;
    half_nxt   = half_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    addr_nxt   = addr_r;
    kind_nxt   = kind_r;
    budget_nxt = budget_r;
    pcnt_nxt   = pcnt_r;
    cs_nxt     = cs_r;
    sck_nxt    = sck_r;
    mosi_nxt   = mosi_r;
    bbyte_nxt  = bbyte_r;
    bvalid_nxt = bvalid_r;
    cdata_nxt  = cdata_r;
    ready_nxt  = ready_r;
    tmo_nxt    = tmo_r;
    buf_stall  = 1'b0;
    if (adv) begin
      if (phase_r == PH_IDLE) begin
        if (in_op_r == OP_READ || in_op_r == OP_PROG || in_op_r == OP_SECT ||
            in_op_r == OP_BULK || in_op_r == OP_STAT) begin
          kind_nxt   = in_op_r;
          addr_nxt   = in_addr_r;
          tmo_nxt    = 1'b0;
          ready_nxt  = 1'b0;
          bvalid_nxt = 1'b0;
          budget_nxt = 32'd0;
          phase_nxt  = PH_START;
          case (in_op_r)
            OP_READ: begin
              frame_nxt = FR_MAIN;
              left_nxt  = in_len_r;
            end
            OP_STAT: begin
              frame_nxt = FR_MAIN;
              left_nxt  = 25'd1;
            end
            OP_PROG: begin
              frame_nxt  = FR_WREN;
              left_nxt   = in_len_r;
              budget_nxt = to_prog_r;
            end
            OP_SECT: begin
              frame_nxt  = FR_WREN;
              left_nxt   = 25'd0;
              budget_nxt = to_sect_r;
            end
            default: begin
              frame_nxt  = FR_WREN;
              left_nxt   = 25'd0;
              budget_nxt = to_bulk_r;
            end
          endcase
        end
      end else begin
        // program byte offer lands in the one-word buffer
        if (in_op_r == OP_BYTE && kind_r == OP_PROG &&
            (frame_r == FR_WREN || frame_r == FR_MAIN) && left_r != 25'd0 && !bvalid_r) begin
          bbyte_nxt  = in_wbyte_r;
          bvalid_nxt = 1'b1;
        end
        case (phase_r)
          PH_START: begin
            cs_nxt    = 1'b0;
            sck_nxt   = 1'b0;
            mosi_nxt  = 1'b0;
            pos_nxt   = '0;
            bit_nxt   = 3'd0;
            half_nxt  = 1'b0;
            phase_nxt = PH_SHIFT;
          end
          PH_SHIFT: begin
            if (!half_r) begin
              sck_nxt = 1'b0;
              if (bit_r == 3'd0) begin
                if (pos_r < hlen) begin
                  shift_nxt = hdr_byte;
                  cdata_nxt = 1'b0;
                end else if (frame_r == FR_MAIN && kind_r == OP_PROG) begin
                  if (bvalid_nxt) begin
                    shift_nxt  = bbyte_nxt;
                    bvalid_nxt = 1'b0;
                    left_nxt   = left_r - 25'd1;
                    cdata_nxt  = 1'b1;
                  end else begin
                    buf_stall = 1'b1;
                  end
                end else begin
                  shift_nxt = 8'h00;
                  left_nxt  = left_r - 25'd1;
                  cdata_nxt = 1'b1;
                end
              end
              // stall with sck low while the program buffer is empty
              if (!buf_stall) begin
                mosi_nxt = shift_nxt[7];
                half_nxt = 1'b1;
              end
            end else begin
              sck_nxt   = 1'b1;
              shift_nxt = shifted;
              bit_nxt   = bit_r + 3'd1;
              half_nxt  = 1'b0;
              if (bit_r == 3'd7) begin
                if (cdata_r) begin
                  if (frame_r == FR_POLL) begin
                    ready_nxt = (shifted & busy_mask_r) == 8'h00;
                  end
                end else begin
                  pos_nxt = pos_r + POS_W'(1);
                end
                if (!((pos_nxt < hlen) || (has_data && left_r != 25'd0))) begin
                  phase_nxt = PH_STOP;
                end
              end
            end
          end
          PH_STOP: begin
            cs_nxt   = 1'b1;
            sck_nxt  = 1'b0;
            mosi_nxt = 1'b0;
            if (frame_r == FR_WREN) begin
              frame_nxt = FR_MAIN;
              phase_nxt = PH_START;
            end else if (frame_r == FR_MAIN && (kind_r == OP_READ || kind_r == OP_STAT)) begin
              phase_nxt = PH_IDLE;
            end else if (frame_r == FR_WRDI) begin
              phase_nxt = PH_IDLE;
            end else if (frame_r == FR_POLL && ready_r) begin
              frame_nxt = FR_WRDI;
              phase_nxt = PH_START;
            end else if (budget_r == 32'd0) begin
              // budget spent: close out with write disable
              tmo_nxt   = 1'b1;
              frame_nxt = FR_WRDI;
              phase_nxt = PH_START;
            end else begin
              budget_nxt = budget_r - wait_w;
              pcnt_nxt   = wait_w[15:0];
              phase_nxt  = PH_WAIT;
            end
          end
          PH_WAIT: begin
            if (pcnt_r != 16'd0) begin
              pcnt_nxt = pcnt_r - 16'd1;
            end
            if (pcnt_r <= 16'd1) begin
              frame_nxt = FR_POLL;
              left_nxt  = 25'd1;
              phase_nxt = PH_START;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // result word
  logic        rvalid;
  logic        rlast;
  logic        want;
  fin_t        fin;
  logic [15:0] res_data;

  always_comb begin
    rvalid = phase_r == PH_SHIFT && half_r && bit_r == 3'd7 && cdata_r &&
             frame_r != FR_POLL && kind_r != OP_PROG;
    rlast  = rvalid && left_r == 25'd0;
    fin    = FIN_NONE;
    if (phase_r == PH_STOP) begin
      if (frame_r == FR_MAIN && (kind_r == OP_READ || kind_r == OP_STAT)) begin
        fin = FIN_OK;
      end else if (frame_r == FR_WRDI) begin
        fin = tmo_r ? FIN_TIMEOUT : FIN_OK;
      end
    end
    want = phase_nxt != PH_IDLE && kind_nxt == OP_PROG &&
           (frame_nxt == FR_WREN || frame_nxt == FR_MAIN) &&
           left_nxt != 25'd0 && !bvalid_nxt;
    res_data = {fin, phase_nxt != PH_IDLE, want, rvalid,
                rvalid ? shifted : 8'h00, mosi_nxt, sck_nxt, cs_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      frame_r  <= FR_WREN;
      pos_r    <= '0;
      bit_r    <= 3'd0;
      half_r   <= 1'b0;
      shift_r  <= 8'h00;
      left_r   <= 25'd0;
      addr_r   <= 24'd0;
      kind_r   <= OP_TICK;
      budget_r <= 32'd0;
      pcnt_r   <= 16'd0;
      cs_r     <= 1'b1;
      sck_r    <= 1'b0;
      mosi_r   <= 1'b0;
      bbyte_r  <= 8'h00;
      bvalid_r <= 1'b0;
      cdata_r  <= 1'b0;
      ready_r  <= 1'b0;
      tmo_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      frame_r  <= frame_nxt;
      pos_r    <= pos_nxt;
      bit_r    <= bit_nxt;
      half_r   <= half_nxt;
      shift_r  <= shift_nxt;
      left_r   <= left_nxt;
      addr_r   <= addr_nxt;
      kind_r   <= kind_nxt;
      budget_r <= budget_nxt;
      pcnt_r   <= pcnt_nxt;
      cs_r     <= cs_nxt;
      sck_r    <= sck_nxt;
      mosi_r   <= mosi_nxt;
      bbyte_r  <= bbyte_nxt;
      bvalid_r <= bvalid_nxt;
      cdata_r  <= cdata_nxt;
      ready_r  <= ready_nxt;
      tmo_r    <= tmo_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_data;
      out_last_r <= rlast;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/snfcs_checker.sv =====
// port-level checks for the spi nor flash command sequencer
`default_nettype none

module snfcs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // no received byte means empty byte field and no last mark
  a_rb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[11] |-> out_tdata[10:3] == 8'h00 && !out_tlast)
    else $error("read byte or last set without read_valid");

  // a finished request leaves the sequencer idle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:14] != 2'd0 |-> !out_tdata[13])
    else $error("finish reported while busy");

  // idle bus: chip select high, clock low
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[13] |-> out_tdata[0] && !out_tdata[1])
    else $error("bus not parked while idle");

  a_fin_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:14] != 2'd3)
    else $error("reserved finish code");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (.*);

`default_nettype wire
